### hw/rtl/uart_dual_ring_buffer_defines.svh
// Assertion macros for the UART dual ring buffer.
// Each macro expects clk and arst_n in scope.
`ifndef UART_DUAL_RING_BUFFER_DEFINES_SVH
`define UART_DUAL_RING_BUFFER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define UDRB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define UDRB_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define UDRB_ASSERT(lbl, prop, msg)

`define UDRB_NEVER(lbl, cond, msg)

`endif

`endif

### hw/rtl/udrb_pkg.sv
package udrb_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W = 6;
	localparam int CNT_W = 32;
	localparam int RX_DEPTH_DEF = 64;
	localparam int TX_DEPTH_DEF = 64;

	typedef enum logic [1:0] {
		MODE_RX_BYTE  = 2'd0,
		MODE_READ     = 2'd1,
		MODE_TX_BYTE  = 2'd2,
		MODE_TX_EMPTY = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [BYTE_W-1:0]  data;
		logic               first_of_string;
		logic               last_of_string;
		logic [LEN_W-1:0]   string_length;
	} cmd_item_t;

	typedef struct packed {
		logic               tx_valid;
		logic [BYTE_W-1:0]  tx_byte;
		logic               read_valid;
		logic [BYTE_W-1:0]  read_byte;
		logic               string_rejected;
		logic               tx_busy_flag;
		logic [CNT_W-1:0]   dropped_count;
	} rsp_item_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic one_left;
	} ring_stat_t;

endpackage

### hw/rtl/udrb_chan.sv
interface udrb_chan #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/udrb_ring.sv
module udrb_ring
	import udrb_pkg::*;
#(
	parameter int DEPTH = RX_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = (AW > LEN_W) ? AW : LEN_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              pop,
	input  logic [BYTE_W-1:0] wdata,
	output logic [BYTE_W-1:0] rdata,
	output ring_stat_t        stat,
	output logic [CW-1:0]     room
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [AW-1:0]     wr_q;
	logic [AW-1:0]     rd_q;
	logic [AW-1:0]     wr_next;
	logic [AW-1:0]     rd_next;
	logic [BYTE_W-1:0] rdata_q;
	logic [BYTE_W-1:0] fwd_data_q;
	logic              fwd_q;

	assign wr_next = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
	assign rd_next = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);

	assign stat.empty    = (rd_q == wr_q);
	assign stat.full     = (wr_next == rd_q);
	assign stat.one_left = (rd_next == wr_q);

	always_comb begin
		if (rd_q > wr_q) begin
			room = CW'(rd_q) - CW'(wr_q) - CW'(1);
		end else begin
			room = CW'(DEPTH - 1) - (CW'(wr_q) - CW'(rd_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			fwd_q <= 1'b0;
		end else begin
			if (push) wr_q <= wr_next;
			if (pop) begin
				rd_q  <= rd_next;
				// popping the entry written in the same cycle
				fwd_q <= push && (rd_q == wr_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= wdata;
		if (pop) begin
			rdata_q    <= mem[rd_q];
			fwd_data_q <= wdata;
		end
	end

	assign rdata = fwd_q ? fwd_data_q : rdata_q;

endmodule

### hw/rtl/uart_dual_ring_buffer.sv
// Receive and transmit byte rings between a UART and software. One command item is
// taken per clock as long as the response side keeps taking results; each response
// item passes through the synchronous read of the ring memory and then the output
// register. The stall-free rate is one item per cycle, set by the single read and
// write port of each ring memory.
`include "uart_dual_ring_buffer_defines.svh"

module uart_dual_ring_buffer
	import udrb_pkg::*;
#(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int TX_DEPTH = TX_DEPTH_DEF,
	localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1,
	localparam int TX_CW = (TX_AW > LEN_W) ? TX_AW : LEN_W
) (
	input  logic      clk,
	input  logic      arst_n,
	udrb_chan.sink    cmd,
	udrb_chan.source  rsp
);

	ring_stat_t        rx_stat;
	ring_stat_t        tx_stat;
	logic [TX_CW-1:0]  tx_room;
	logic [BYTE_W-1:0] rx_rdata;
	logic [BYTE_W-1:0] tx_rdata;

	logic              rx_push;
	logic              rx_pop;
	logic              tx_push;
	logic              tx_pop;
	logic              rejected;
	logic              drop_now;
	logic              sending_d;
	logic              dropping_d;
	logic              tally_inc;

	logic              sending_q;
	logic              dropping_q;
	logic [CNT_W-1:0]  tally_q;

	logic              valid_s1;
	logic              rx_pop_s1;
	logic              tx_pop_s1;
	logic              rejected_s1;

	logic              out_valid_q;
	rsp_item_t         out_q;
	rsp_item_t         out_d;

	logic              cmd_fire;
	logic              adv_s1;
	cmd_item_t         item;

	assign item     = cmd.payload;
	assign adv_s1   = valid_s1 && (!out_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || adv_s1;
	assign cmd_fire = cmd.valid && cmd.ready;

	always_comb begin
		rx_push    = 1'b0;
		rx_pop     = 1'b0;
		tx_push    = 1'b0;
		tx_pop     = 1'b0;
		rejected   = 1'b0;
		drop_now   = dropping_q;
		tally_inc  = 1'b0;
		sending_d  = sending_q;
		dropping_d = dropping_q;
		if (cmd_fire) begin
			unique case (item.mode)
				MODE_RX_BYTE: begin
					rx_push   = !rx_stat.full;
					tally_inc = rx_stat.full;
				end
				MODE_READ: begin
					rx_pop = !rx_stat.empty;
				end
				MODE_TX_BYTE: begin
					if (item.first_of_string) begin
						drop_now = TX_CW'(item.string_length) > tx_room;
					end
					if (tx_stat.full) drop_now = 1'b1;
					rejected = drop_now;
					tx_push  = !drop_now;
					if (!drop_now && item.last_of_string && !sending_q) begin
						sending_d = 1'b1;
						tx_pop    = 1'b1;
					end
					dropping_d = item.last_of_string ? 1'b0 : drop_now;
				end
				MODE_TX_EMPTY: begin
					tx_pop = sending_q && !tx_stat.empty;
					if (tx_pop && tx_stat.one_left) sending_d = 1'b0;
				end
				default: ;
			endcase
		end
	end

	udrb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rx_push),
		.pop   (rx_pop),
		.wdata (item.data),
		.rdata (rx_rdata),
		.stat  (rx_stat),
		.room  ()
	);

	udrb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (tx_push),
		.pop   (tx_pop),
		.wdata (item.data),
		.rdata (tx_rdata),
		.stat  (tx_stat),
		.room  (tx_room)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sending_q  <= 1'b0;
			dropping_q <= 1'b0;
			tally_q    <= '0;
		end else begin
			sending_q  <= sending_d;
			dropping_q <= dropping_d;
			if (tally_inc) tally_q <= tally_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			rx_pop_s1   <= rx_pop;
			tx_pop_s1   <= tx_pop;
			rejected_s1 <= rejected;
		end
	end

	// state registers already hold the post-item values while the item sits in s1
	always_comb begin
		out_d.tx_valid        = tx_pop_s1;
		out_d.tx_byte         = tx_pop_s1 ? tx_rdata : '0;
		out_d.read_valid      = rx_pop_s1;
		out_d.read_byte       = rx_pop_s1 ? rx_rdata : '0;
		out_d.string_rejected = rejected_s1;
		out_d.tx_busy_flag    = sending_q;
		out_d.dropped_count   = tally_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) out_q <= out_d;
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	`UDRB_NEVER(a_tx_pop_empty, tx_pop && tx_stat.empty && !tx_push, "tx pop on empty ring")
	`UDRB_NEVER(a_rx_push_full, rx_push && rx_stat.full, "rx push on full ring")
	`UDRB_ASSERT(a_tally_step, (tally_q != $past(tally_q)) |-> (tally_q == $past(tally_q) + CNT_W'(1)), "overflow count jumped")

endmodule

### tb/uart_dual_ring_buffer_test.sv
`timescale 1ns / 100ps

module uart_dual_ring_buffer_test
	import udrb_pkg::*;
;

	localparam int RX_N = RX_DEPTH_DEF;
	localparam int TX_N = TX_DEPTH_DEF;

	logic clk = 1'b0;
	logic arst_n;

	udrb_chan #(.T(cmd_item_t)) cmd_if ();
	udrb_chan #(.T(rsp_item_t)) rsp_if ();

	uart_dual_ring_buffer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow copy of both rings
	logic [7:0]  rx_ring [RX_N];
	int          rx_wr = 0;
	int          rx_rd = 0;
	logic [7:0]  tx_ring [TX_N];
	int          tx_wr = 0;
	int          tx_rd = 0;
	bit          tx_sending = 1'b0;
	bit          string_dropped = 1'b0;
	logic [31:0] overflow_cnt = '0;

	rsp_item_t   pending_replies [$];
	int          err_cnt = 0;
	int          sent_items = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;

	function automatic int ring_room(int wr, int rd, int depth);
		return (rd > wr) ? rd - wr - 1 : depth - 1 - (wr - rd);
	endfunction

	function automatic int bump(int i, int depth);
		return (i + 1 >= depth) ? 0 : i + 1;
	endfunction

	function automatic rsp_item_t advance_rings(cmd_item_t c);
		rsp_item_t r;
		int room;
		r = '0;
		case (c.mode)
			MODE_RX_BYTE: begin
				if (ring_room(rx_wr, rx_rd, RX_N) > 0) begin
					rx_ring[rx_wr] = c.data;
					rx_wr = bump(rx_wr, RX_N);
				end else begin
					overflow_cnt = overflow_cnt + 32'd1;
				end
			end
			MODE_READ: begin
				if (rx_rd != rx_wr) begin
					r.read_valid = 1'b1;
					r.read_byte = rx_ring[rx_rd];
					rx_rd = bump(rx_rd, RX_N);
				end
			end
			MODE_TX_BYTE: begin
				room = ring_room(tx_wr, tx_rd, TX_N);
				if (c.first_of_string)
					string_dropped = int'(c.string_length) > room;
				if (!string_dropped && room == 0)
					string_dropped = 1'b1;
				if (string_dropped) begin
					r.string_rejected = 1'b1;
				end else begin
					tx_ring[tx_wr] = c.data;
					tx_wr = bump(tx_wr, TX_N);
					if (c.last_of_string && !tx_sending) begin
						tx_sending = 1'b1;
						r.tx_valid = 1'b1;
						r.tx_byte = tx_ring[tx_rd];
						tx_rd = bump(tx_rd, TX_N);
					end
				end
				if (c.last_of_string)
					string_dropped = 1'b0;
			end
			default: begin
				if (tx_sending && tx_rd != tx_wr) begin
					r.tx_valid = 1'b1;
					r.tx_byte = tx_ring[tx_rd];
					tx_rd = bump(tx_rd, TX_N);
					if (tx_rd == tx_wr)
						tx_sending = 1'b0;
				end
			end
		endcase
		r.tx_busy_flag = tx_sending;
		r.dropped_count = overflow_cnt;
		return r;
	endfunction

	function automatic cmd_item_t rand_cmd(mode_t m);
		cmd_item_t c;
		c.mode = m;
		c.data = 8'($urandom_range(255));
		c.first_of_string = 1'($urandom_range(1));
		c.last_of_string = 1'($urandom_range(1));
		c.string_length = 6'($urandom_range(63));
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		err_cnt++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h exp %0h", name, got, want));
	endtask

	task automatic check_reply(input rsp_item_t got);
		rsp_item_t want;
		if (pending_replies.size() == 0) begin
			report_mismatch("result with no item pending");
			return;
		end
		want = pending_replies.pop_front();
		compare_field("tx_valid", got.tx_valid, want.tx_valid);
		compare_field("tx_byte", got.tx_byte, want.tx_byte);
		compare_field("read_valid", got.read_valid, want.read_valid);
		compare_field("read_byte", got.read_byte, want.read_byte);
		compare_field("string_rejected", got.string_rejected, want.string_rejected);
		compare_field("tx_busy_flag", got.tx_busy_flag, want.tx_busy_flag);
		compare_field("dropped_count", got.dropped_count, want.dropped_count);
	endtask

	// response side: random stall, check on handshake
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready)
				check_reply(rsp_if.payload);
			rsp_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_cmd(input cmd_item_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.payload <= c;
		do
			@(posedge clk);
		while (!cmd_if.ready);
		pending_replies.push_back(advance_rings(c));
		sent_items++;
	endtask

	task automatic send_mode(input mode_t m, input logic [7:0] d);
		cmd_item_t c;
		c = rand_cmd(m);
		c.data = d;
		send_cmd(c);
	endtask

	task automatic send_str_byte(input logic [7:0] d, input bit first, input bit last,
			input int len);
		cmd_item_t c;
		c = rand_cmd(MODE_TX_BYTE);
		c.data = d;
		c.first_of_string = first;
		c.last_of_string = last;
		c.string_length = 6'(len);
		send_cmd(c);
	endtask

	task automatic test_idle_ops();
		send_mode(MODE_READ, 8'h00);
		send_mode(MODE_TX_EMPTY, 8'h00);
	endtask

	task automatic test_rx_path();
		send_mode(MODE_RX_BYTE, 8'h00);
		send_mode(MODE_RX_BYTE, 8'hFF);
		send_mode(MODE_READ, 8'h00);
		send_mode(MODE_READ, 8'h00);
		send_mode(MODE_READ, 8'h00);
	endtask

	task automatic test_single_byte_string();
		send_str_byte(8'hA5, 1'b1, 1'b1, 1);
		send_mode(MODE_TX_EMPTY, 8'h00);
	endtask

	task automatic test_string_flow();
		send_str_byte(8'h5A, 1'b1, 1'b0, 3);
		send_str_byte(8'hFF, 1'b0, 1'b0, 0);
		send_str_byte(8'h00, 1'b0, 1'b1, 0);
		repeat (4) send_mode(MODE_TX_EMPTY, 8'h00);
	endtask

	task automatic test_zero_length();
		send_str_byte(8'h3C, 1'b1, 1'b0, 0);
		send_str_byte(8'hC3, 1'b0, 1'b1, 0);
	endtask

	// too long on first byte, then a byte that continues without a first
	task automatic test_oversize_string();
		send_str_byte(8'h11, 1'b1, 1'b0, 63);
		send_str_byte(8'h22, 1'b0, 1'b0, 63);
		send_str_byte(8'h33, 1'b0, 1'b1, 0);
		send_str_byte(8'h44, 1'b0, 1'b1, 0);
		repeat (2) send_mode(MODE_TX_EMPTY, 8'h00);
	endtask

	task automatic send_string(input int n, input int len);
		for (int i = 0; i < n; i++)
			send_str_byte(8'($urandom_range(255)), i == 0, i == n - 1, len);
	endtask

	task automatic send_burst(input mode_t m, input int n);
		for (int i = 0; i < n; i++)
			send_cmd(rand_cmd(m));
	endtask

	task automatic test_random_traffic(input int n_items, input int unsigned idle,
			input int unsigned stall);
		int stop_at;
		int kind;
		int n;
		int len;
		send_idle_pct = idle;
		stall_pct = stall;
		stop_at = sent_items + n_items;
		while (sent_items < stop_at) begin
			kind = $urandom_range(99);
			if (kind < 22) begin
				n = ($urandom_range(7) == 0) ? $urandom_range(80, 64) : $urandom_range(20, 1);
				send_burst(MODE_RX_BYTE, n);
			end else if (kind < 42) begin
				n = ($urandom_range(7) == 0) ? $urandom_range(70, 60) : $urandom_range(20, 1);
				send_burst(MODE_READ, n);
			end else if (kind < 72) begin
				n = ($urandom_range(5) == 0) ? $urandom_range(63, 40) : $urandom_range(16, 1);
				len = $urandom_range(99);
				if (len < 60)
					len = n;
				else if (len < 80)
					len = $urandom_range(n, 0);
				else
					len = $urandom_range(63, n);
				send_string(n, len);
			end else if (kind < 92) begin
				send_burst(MODE_TX_EMPTY, $urandom_range(30, 1));
			end else begin
				repeat ($urandom_range(6, 1))
					send_cmd(rand_cmd(mode_t'($urandom_range(3))));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.payload = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ops();
		test_rx_path();
		test_single_byte_string();
		test_string_flow();
		test_zero_length();
		test_oversize_string();

		test_random_traffic(360, 0, 0);
		test_random_traffic(360, 86, 0);
		test_random_traffic(360, 0, 86);
		test_random_traffic(360, 21, 21);

		cmd_if.valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (pending_replies.size() != 0)
			report_mismatch("items left without a result");
		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/udrb_pkg.sv
hw/rtl/udrb_chan.sv
hw/rtl/udrb_ring.sv
hw/rtl/uart_dual_ring_buffer.sv
tb/uart_dual_ring_buffer_test.sv
